// ===== design/csvtok_pkg.sv =====
// csvtok_pkg: shared types and constants for the CSV record tokenizer.
// No dependencies; used by the channel interfaces, the parser and the top level.
package csvtok_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] SEP_RESET  = 8'd44;
  localparam logic [7:0] COLS_RESET = 8'd0;

  // register index, taken from paddr[2]
  localparam logic REG_FIELD_SEPARATOR  = 1'b0;
  localparam logic REG_EXPECTED_COLUMNS = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       field_end;
    logic       record_end;
    logic       record_error;
    logic [7:0] field_count;
    logic       column_mismatch;
    logic       input_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] field_separator;
    logic [7:0] expected_columns;
  } cfg_t;

endpackage

// ===== design/csvtok_if.sv =====
// csvtok_if: valid/ready channel interfaces for characters in and tokens out.
// Depends on csvtok_pkg for the beat payload types.
interface csvtok_in_if;
  import csvtok_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface csvtok_out_if;
  import csvtok_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/csvtok_parser.sv =====
// csvtok_parser: parse mode and field counter, one character per accepted beat.
// Depends on csvtok_pkg; produces at most one token beat per character.
module csvtok_parser #(
  parameter int MAX_FIELDS = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  csvtok_pkg::in_item_t  item,
  input  csvtok_pkg::cfg_t      cfg,
  output logic                  res_valid,
  output csvtok_pkg::out_item_t res
);
  import csvtok_pkg::*;

  localparam logic [7:0] FieldCap = (MAX_FIELDS < 255) ? 8'(MAX_FIELDS) : 8'd255;

  localparam logic [2:0] M_REC      = 3'd0;
  localparam logic [2:0] M_FIELD    = 3'd1;
  localparam logic [2:0] M_FIELD_WS = 3'd2;
  localparam logic [2:0] M_PLAIN    = 3'd3;
  localparam logic [2:0] M_QUOTED   = 3'd4;
  localparam logic [2:0] M_QSEEN    = 3'd5;

  logic [2:0] mode, mode_next;
  logic [7:0] fields_seen, fields_seen_next;

  logic [2:0] m;
  logic [7:0] c;
  logic       is_eol, is_sep, is_ws, count, emit, restart;
  logic [7:0] fcount;

  always_comb begin
    c         = item.char_in;
    is_eol    = (c == CH_CR) || (c == CH_LF);
    is_sep    = (c == cfg.field_separator);
    is_ws     = (c == CH_SPACE) || (c == CH_TAB);
    m         = (mode > M_QSEEN) ? M_REC : mode;
    mode_next = m;
    count     = 1'b0;
    emit      = 1'b0;
    res       = '0;

    if (item.end_of_input) begin
      emit           = 1'b1;
      res.input_done = 1'b1;
      case (m)
        M_FIELD, M_FIELD_WS: res.record_end = 1'b1;
        M_PLAIN, M_QSEEN: begin
          count          = 1'b1;
          res.field_end  = 1'b1;
          res.record_end = 1'b1;
        end
        M_QUOTED: res.record_error = 1'b1;
        default: ;
      endcase
    end else if ((m == M_REC && is_eol) || (m == M_FIELD_WS && is_ws)) begin
      emit = 1'b0;
    end else begin
      if (m == M_REC || m == M_FIELD_WS) m = M_FIELD;
      case (m)
        M_FIELD: begin
          if (c == CH_QUOTE) begin
            mode_next = M_QUOTED;
          end else if (is_eol) begin
            emit           = 1'b1;
            res.record_end = 1'b1;
          end else if (is_sep) begin
            emit          = 1'b1;
            count         = 1'b1;
            res.field_end = 1'b1;
            mode_next     = M_FIELD_WS;
          end else begin
            emit           = 1'b1;
            res.data_byte  = c;
            res.byte_valid = 1'b1;
            mode_next      = M_PLAIN;
          end
        end
        M_PLAIN: begin
          emit = 1'b1;
          if (is_sep) begin
            count         = 1'b1;
            res.field_end = 1'b1;
            mode_next     = M_FIELD;
          end else if (is_eol) begin
            count          = 1'b1;
            res.field_end  = 1'b1;
            res.record_end = 1'b1;
          end else begin
            res.data_byte  = c;
            res.byte_valid = 1'b1;
          end
        end
        M_QUOTED: begin
          if (c == CH_QUOTE) begin
            mode_next = M_QSEEN;
          end else begin
            emit           = 1'b1;
            res.data_byte  = c;
            res.byte_valid = 1'b1;
          end
        end
        default: begin
          emit = 1'b1;
          if (c == CH_QUOTE) begin
            res.data_byte  = CH_QUOTE;
            res.byte_valid = 1'b1;
            mode_next      = M_QUOTED;
          end else if (is_sep) begin
            count         = 1'b1;
            res.field_end = 1'b1;
            mode_next     = M_FIELD;
          end else if (is_eol) begin
            count          = 1'b1;
            res.field_end  = 1'b1;
            res.record_end = 1'b1;
          end else begin
            res.record_error = 1'b1;
          end
        end
      endcase
    end

    fcount = (count && fields_seen < FieldCap) ? fields_seen + 8'd1 : fields_seen;
    res.field_count     = fcount;
    res.column_mismatch = res.record_end && (cfg.expected_columns != 8'd0)
                          && (fcount != cfg.expected_columns);
    restart   = emit && (res.record_end || res.record_error || res.input_done);
    res_valid = accept && emit;

    fields_seen_next = restart ? 8'd0 : fcount;
    if (restart) mode_next = M_REC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_REC;
      fields_seen <= 8'd0;
    end else if (accept) begin
      mode        <= mode_next;
      fields_seen <= fields_seen_next;
    end
  end

  a_eoi_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_input |=> mode == M_REC && fields_seen == 8'd0)
    else $error("parser not back at record start after end of input");

  a_mismatch_at_record_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.column_mismatch |-> res.record_end)
    else $error("column mismatch flagged outside record end");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    fields_seen <= FieldCap)
    else $error("field counter above its cap");

endmodule

// ===== design/csv_record_tokenizer_core.sv =====
// csv_record_tokenizer_core: streaming CSV tokenizer with APB setup registers.
// Depends on csvtok_pkg, csvtok_in_if/csvtok_out_if and csvtok_parser.
//
// rx carries one character or an end-of-input mark per beat; tx carries at
// most one token beat per character: a content byte, a field end, a record
// end or error with the field count and column check, or the end-of-input
// flag. Quotes that open or close a field, blank lines and whitespace after
// an empty field give no tx beat.
// Each token is registered in the output register, or in the skid register
// while tx stalls; one character is taken every cycle unless the skid is full.
// An output register plus a one-entry skid register sit on tx, so rx keeps
// flowing while a token waits; rx.ready drops only while the skid register
// is full, and rises again the cycle after tx takes a beat.
// Reset empties both registers, returns the parser to record start with no
// fields counted, and loads the separator with ',' and the column check off.
// APB: separator at 0x0, expected column count at 0x4; write only while idle.
module csv_record_tokenizer_core #(
  parameter int MAX_FIELDS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  csvtok_in_if.sink   rx,
  csvtok_out_if.source tx
);
  import csvtok_pkg::*;

  cfg_t      cfg;
  logic      accept;
  logic      res_valid;
  out_item_t res;

  logic      out_valid;
  out_item_t out_data;
  logic      skid_valid;
  out_item_t skid_data;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXPECTED_COLUMNS) ? {24'd0, cfg.expected_columns}
                                                     : {24'd0, cfg.field_separator};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_separator  <= SEP_RESET;
      cfg.expected_columns <= COLS_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_FIELD_SEPARATOR) cfg.field_separator  <= pwdata[7:0];
      else                                 cfg.expected_columns <= pwdata[7:0];
    end
  end

  assign rx.ready = !skid_valid;
  assign accept   = rx.valid && rx.ready;

  csvtok_parser #(.MAX_FIELDS(MAX_FIELDS)) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (rx.payload),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || tx.ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || tx.ready) begin
      out_data <= skid_valid ? skid_data : res;
      if (skid_valid && res_valid) skid_data <= res;
    end else if (res_valid) begin
      skid_data <= res;
    end
  end

  assign tx.valid   = out_valid;
  assign tx.payload = out_data;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !tx.ready |=> skid_valid && $stable(skid_data))
    else $error("skid beat lost during stall");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_valid && !tx.ready |-> !res_valid)
    else $error("token produced with nowhere to store it");

endmodule
